FILE: rtl/contour_parity_crossing_count_core_defines.svh
// assertion macros shared by the contour parity crossing count core
`ifndef CONTOUR_PARITY_CROSSING_COUNT_CORE_DEFINES_SVH
`define CONTOUR_PARITY_CROSSING_COUNT_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define CPCC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off while rst_ni is low
`define CPCC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/cpcc_pkg.sv
// shared constants and controller/datapath interface types
`timescale 1ns / 1ps
package cpcc_pkg;

  localparam int unsigned LEFT_START_X = 65536;
  localparam int unsigned IDX_W        = 4;
  localparam int unsigned CNT_OUT_W    = 9;
  localparam int unsigned OUT_DW       = 16;

  typedef struct packed {
    logic xy_we;
    logic end_we;
    logic end_bit;
    logic rd_en;
    logic left_init;
    logic left_upd;
    logic walk_first;
    logic walk_next;
    logic edge_fire;
    logic edge_close;
    logic cnt_clr;
  } cpcc_cmd_t;

  typedef struct packed {
    logic rd_end;
    logic pipe_empty;
  } cpcc_sts_t;

endpackage

FILE: rtl/contour_parity_crossing_count_core.sv
// top level of the contour parity crossing count core
//
//  channel  dir  tdata                                  tuser        tlast
//  s_axis   in   vertex_x, vertex_y                     contour_end  glyph_end
//  m_axis   out  contour_index, crossing_count          overflow     last_contour
//
// loading takes one vertex beat a cycle; a beat with glyph_end starts the compute phase unless no contour was recorded
// per contour the compute time is set by the single read port of the vertex memory,
// walked once per contour
// s_axis_tready is low from glyph end until the final result beat is taken
// a result waits in the output register until m_axis_tready; no clearing pass after reset
`timescale 1ns / 1ps
`include "contour_parity_crossing_count_core_defines.svh"
module contour_parity_crossing_count_core
  import cpcc_pkg::*;
#(
  parameter int unsigned MAX_VERTICES = 256,
  parameter int unsigned MAX_CONTOURS = 16,
  parameter int unsigned COORD_BITS   = 18
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  s_axis_tvalid_i,
  output logic                                  s_axis_tready_o,
  // vertex_x, vertex_y, zero fill
  input  logic [((2*COORD_BITS+7)/8)*8-1:0]     s_axis_tdata_i,
  // contour_end
  input  logic                                  s_axis_tuser_i,
  input  logic                                  s_axis_tlast_i,
  output logic                                  m_axis_tvalid_o,
  input  logic                                  m_axis_tready_i,
  // contour_index, crossing_count, zero fill
  output logic [OUT_DW-1:0]                     m_axis_tdata_o,
  // overflow
  output logic                                  m_axis_tuser_o,
  output logic                                  m_axis_tlast_o
);

  localparam int unsigned AW   = $clog2(MAX_VERTICES);
  localparam int unsigned CNTW = $clog2(MAX_VERTICES + 1);

  cpcc_cmd_t                    cmd;
  cpcc_sts_t                    sts;
  logic [AW-1:0]                wr_addr, end_addr, rd_addr;
  logic [CNTW-1:0]              count;
  logic signed [COORD_BITS-1:0] vx, vy;
  logic [IDX_W-1:0]             out_idx;
  logic [CNT_OUT_W-1:0]         out_cnt;

  assign vx = $signed(s_axis_tdata_i[COORD_BITS-1:0]);
  assign vy = $signed(s_axis_tdata_i[2*COORD_BITS-1:COORD_BITS]);

  cpcc_ctrl #(
    .MAX_VERTICES (MAX_VERTICES),
    .MAX_CONTOURS (MAX_CONTOURS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .cend_i      (s_axis_tuser_i),
    .gend_i      (s_axis_tlast_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_idx_o   (out_idx),
    .out_cnt_o   (out_cnt),
    .out_ovf_o   (m_axis_tuser_o),
    .out_last_o  (m_axis_tlast_o),
    .cmd_o       (cmd),
    .wr_addr_o   (wr_addr),
    .end_addr_o  (end_addr),
    .rd_addr_o   (rd_addr),
    .sts_i       (sts),
    .count_i     (count)
  );

  cpcc_dp #(
    .COORD_BITS   (COORD_BITS),
    .MAX_VERTICES (MAX_VERTICES)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .wr_addr_i  (wr_addr),
    .end_addr_i (end_addr),
    .rd_addr_i  (rd_addr),
    .vx_i       (vx),
    .vy_i       (vy),
    .sts_o      (sts),
    .count_o    (count)
  );

  assign m_axis_tdata_o = {(OUT_DW - IDX_W - CNT_OUT_W)'(0), out_cnt, out_idx};

  `CPCC_ASSERT_NOW(a_no_load_while_result, m_axis_tvalid_o, !s_axis_tready_o,
                   "input open while a result waits")
  `CPCC_ASSERT_NEXT(a_load_after_final,
                    m_axis_tvalid_o && m_axis_tready_i && m_axis_tlast_o,
                    s_axis_tready_o, "not ready for next glyph after final result")
  `CPCC_ASSERT_NEXT(a_busy_after_inner,
                    m_axis_tvalid_o && m_axis_tready_i && !m_axis_tlast_o,
                    !s_axis_tready_o && !m_axis_tvalid_o, "input opened before final result")
  `CPCC_ASSERT_NEXT(a_stay_loading,
                    s_axis_tvalid_i && s_axis_tready_o && !s_axis_tlast_i,
                    s_axis_tready_o, "load phase left without glyph end")

endmodule

FILE: rtl/cpcc_edge.sv
// edge crossing test pipeline and crossing counter
`timescale 1ns / 1ps
module cpcc_edge
  import cpcc_pkg::*;
#(
  parameter int unsigned COORD_BITS   = 18,
  parameter int unsigned MAX_VERTICES = 256
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  valid_i,
  input  logic                                  clr_i,
  input  logic signed [COORD_BITS-1:0]          x1_i,
  input  logic signed [COORD_BITS-1:0]          y1_i,
  input  logic signed [COORD_BITS-1:0]          x2_i,
  input  logic signed [COORD_BITS-1:0]          y2_i,
  input  logic signed [((COORD_BITS > 18) ? COORD_BITS : 18)-1:0] lx_i,
  input  logic signed [COORD_BITS-1:0]          ly_i,
  output logic [$clog2(MAX_VERTICES+1)-1:0]     count_o,
  output logic                                  empty_o
);

  localparam int unsigned LW   = (COORD_BITS > 18) ? COORD_BITS : 18;
  localparam int unsigned DXW  = LW + 1;
  localparam int unsigned DYW  = COORD_BITS + 1;
  localparam int unsigned PW   = DXW + DYW;
  localparam int unsigned CNTW = $clog2(MAX_VERTICES + 1);

  logic signed [LW-1:0]  x1e, x2e;
  logic                  rej_d, acc_d;
  logic signed [DXW-1:0] dx1_d, dx2_d;
  logic signed [DYW-1:0] dy1_d, dy2_d;

  logic                  v1_q, rej1_q, acc1_q;
  logic signed [DXW-1:0] dx1_q, dx2_q;
  logic signed [DYW-1:0] dy1_q, dy2_q;

  logic                  v2_q, rej2_q, acc2_q;
  logic signed [PW-1:0]  p1_d, p2_d, p1_q, p2_q;

  logic [CNTW-1:0]       count_q, count_d;

  assign x1e = LW'(x1_i);
  assign x2e = LW'(x2_i);

  // trivial rejection and acceptance against the leftmost point
  assign rej_d = ((y1_i < ly_i) && (y2_i < ly_i)) ||
                 ((y1_i >= ly_i) && (y2_i >= ly_i)) ||
                 ((x1e > lx_i) && (x2e > lx_i));
  assign acc_d = (x1e < lx_i) && (x2e < lx_i);

  assign dx1_d = DXW'(x1e) - DXW'(lx_i);
  assign dx2_d = DXW'(x2e) - DXW'(lx_i);
  assign dy1_d = DYW'(y1_i) - DYW'(ly_i);
  assign dy2_d = DYW'(y2_i) - DYW'(ly_i);

  assign p1_d = dx2_q * dy1_q;
  assign p2_d = dy2_q * dx1_q;

  always_comb begin
    count_d = count_q;
    if (clr_i) begin
      count_d = '0;
    end else if (v2_q && !rej2_q && (acc2_q || (p1_q > p2_q))) begin
      count_d = count_q + CNTW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      count_q <= '0;
    end else begin
      v1_q    <= valid_i;
      v2_q    <= v1_q;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rej1_q <= rej_d;
    acc1_q <= acc_d;
    dx1_q  <= dx1_d;
    dx2_q  <= dx2_d;
    dy1_q  <= dy1_d;
    dy2_q  <= dy2_d;
    rej2_q <= rej1_q;
    acc2_q <= acc1_q;
    p1_q   <= p1_d;
    p2_q   <= p2_d;
  end

  assign count_o = count_q;
  assign empty_o = !v1_q && !v2_q;

endmodule

FILE: rtl/cpcc_dp.sv
// datapath: vertex memories, leftmost point, edge endpoints
`timescale 1ns / 1ps
module cpcc_dp
  import cpcc_pkg::*;
#(
  parameter int unsigned COORD_BITS   = 18,
  parameter int unsigned MAX_VERTICES = 256
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  cpcc_cmd_t                         cmd_i,
  input  logic [$clog2(MAX_VERTICES)-1:0]   wr_addr_i,
  input  logic [$clog2(MAX_VERTICES)-1:0]   end_addr_i,
  input  logic [$clog2(MAX_VERTICES)-1:0]   rd_addr_i,
  input  logic signed [COORD_BITS-1:0]      vx_i,
  input  logic signed [COORD_BITS-1:0]      vy_i,
  output cpcc_sts_t                         sts_o,
  output logic [$clog2(MAX_VERTICES+1)-1:0] count_o
);

  localparam int unsigned LW = (COORD_BITS > 18) ? COORD_BITS : 18;

  logic signed [COORD_BITS-1:0] mem_x [MAX_VERTICES];
  logic signed [COORD_BITS-1:0] mem_y [MAX_VERTICES];
  logic                         mem_e [MAX_VERTICES];

  logic signed [COORD_BITS-1:0] rx_q, ry_q;
  logic                         re_q;
  logic signed [LW-1:0]         lx_q;
  logic signed [COORD_BITS-1:0] ly_q;
  logic signed [COORD_BITS-1:0] fx_q, fy_q, px_q, py_q;
  logic signed [COORD_BITS-1:0] e_x2, e_y2;
  logic                         empty;

  // vertex store plus contour end marks
  always_ff @(posedge clk_i) begin
    if (cmd_i.xy_we) begin
      mem_x[wr_addr_i] <= vx_i;
      mem_y[wr_addr_i] <= vy_i;
    end
    if (cmd_i.end_we) begin
      mem_e[end_addr_i] <= cmd_i.end_bit;
    end
    if (cmd_i.rd_en) begin
      rx_q <= mem_x[rd_addr_i];
      ry_q <= mem_y[rd_addr_i];
      re_q <= mem_e[rd_addr_i];
    end
  end

  // leftmost point and walk registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.left_init) begin
      lx_q <= LW'(LEFT_START_X);
      ly_q <= '0;
    end else if (cmd_i.left_upd && (LW'(rx_q) < lx_q)) begin
      lx_q <= LW'(rx_q);
      ly_q <= ry_q;
    end
    if (cmd_i.walk_first) begin
      fx_q <= rx_q;
      fy_q <= ry_q;
    end
    if (cmd_i.walk_first || cmd_i.walk_next) begin
      px_q <= rx_q;
      py_q <= ry_q;
    end
  end

  assign e_x2 = cmd_i.edge_close ? fx_q : rx_q;
  assign e_y2 = cmd_i.edge_close ? fy_q : ry_q;

  cpcc_edge #(
    .COORD_BITS   (COORD_BITS),
    .MAX_VERTICES (MAX_VERTICES)
  ) u_edge (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (cmd_i.edge_fire),
    .clr_i   (cmd_i.cnt_clr),
    .x1_i    (px_q),
    .y1_i    (py_q),
    .x2_i    (e_x2),
    .y2_i    (e_y2),
    .lx_i    (lx_q),
    .ly_i    (ly_q),
    .count_o (count_o),
    .empty_o (empty)
  );

  assign sts_o.rd_end     = re_q;
  assign sts_o.pipe_empty = empty;

endmodule

FILE: rtl/cpcc_ctrl.sv
// controller: load bookkeeping, contour sequencing and result register
`timescale 1ns / 1ps
module cpcc_ctrl
  import cpcc_pkg::*;
#(
  parameter int unsigned MAX_VERTICES = 256,
  parameter int unsigned MAX_CONTOURS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              cend_i,
  input  logic                              gend_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [IDX_W-1:0]                  out_idx_o,
  output logic [CNT_OUT_W-1:0]              out_cnt_o,
  output logic                              out_ovf_o,
  output logic                              out_last_o,
  output cpcc_cmd_t                         cmd_o,
  output logic [$clog2(MAX_VERTICES)-1:0]   wr_addr_o,
  output logic [$clog2(MAX_VERTICES)-1:0]   end_addr_o,
  output logic [$clog2(MAX_VERTICES)-1:0]   rd_addr_o,
  input  cpcc_sts_t                         sts_i,
  input  logic [$clog2(MAX_VERTICES+1)-1:0] count_i
);

  localparam int unsigned AW  = $clog2(MAX_VERTICES);
  localparam int unsigned VCW = $clog2(MAX_VERTICES + 1);
  localparam int unsigned CCW = $clog2(MAX_CONTOURS + 1);

  localparam logic [2:0] ST_LOAD    = 3'd0;
  localparam logic [2:0] ST_LEFT_RD = 3'd1;
  localparam logic [2:0] ST_LEFT_EV = 3'd2;
  localparam logic [2:0] ST_WALK_RD = 3'd3;
  localparam logic [2:0] ST_WALK_EV = 3'd4;
  localparam logic [2:0] ST_WALK_CL = 3'd5;
  localparam logic [2:0] ST_DRAIN   = 3'd6;
  localparam logic [2:0] ST_EMIT    = 3'd7;

  logic [2:0]     state_q, state_d;
  logic [VCW-1:0] vcnt_q, vcnt_d, start_q, start_d;
  logic [CCW-1:0] ccnt_q, ccnt_d, ci_q, ci_d, j_q, j_d;
  logic           ovf_q, ovf_d, first_q, first_d;
  logic [AW-1:0]  addr_q, addr_d, nstart_q, nstart_d;

  logic [IDX_W-1:0]     oidx_q;
  logic [CNT_OUT_W-1:0] ocnt_q;
  logic                 olast_q;
  logic                 out_load;

  logic           acc, stored, closes, nonempty, full, recorded, released;
  logic [VCW-1:0] vcnt_new, vcnt_prev;
  logic [CCW-1:0] ccnt_last;

  assign acc       = in_valid_i && (state_q == ST_LOAD);
  assign stored    = vcnt_q < VCW'(MAX_VERTICES);
  assign vcnt_new  = stored ? (vcnt_q + VCW'(1)) : vcnt_q;
  assign vcnt_prev = vcnt_q - VCW'(1);
  assign closes    = cend_i || gend_i;
  assign nonempty  = vcnt_new != start_q;
  assign full      = ccnt_q == CCW'(MAX_CONTOURS);
  assign recorded  = closes && nonempty && !full;
  assign released  = closes && nonempty && full;
  assign ccnt_last = ccnt_q - CCW'(1);

  always_comb begin
    state_d  = state_q;
    vcnt_d   = vcnt_q;
    start_d  = start_q;
    ccnt_d   = ccnt_q;
    ovf_d    = ovf_q;
    ci_d     = ci_q;
    j_d      = j_q;
    first_d  = first_q;
    addr_d   = addr_q;
    nstart_d = nstart_q;
    out_load = 1'b0;
    cmd_o    = '0;

    case (state_q)
      ST_LOAD: begin
        if (acc) begin
          cmd_o.xy_we   = stored;
          cmd_o.end_we  = stored || recorded;
          cmd_o.end_bit = recorded;
          vcnt_d  = released ? start_q : vcnt_new;
          start_d = recorded ? vcnt_new : start_q;
          ccnt_d  = recorded ? (ccnt_q + CCW'(1)) : ccnt_q;
          ovf_d   = ovf_q || !stored || released;
          if (gend_i) begin
            if (!recorded && (ccnt_q == '0)) begin
              vcnt_d  = '0;
              start_d = '0;
              ovf_d   = 1'b0;
            end else begin
              ci_d            = '0;
              addr_d          = '0;
              cmd_o.left_init = 1'b1;
              cmd_o.cnt_clr   = 1'b1;
              state_d         = ST_LEFT_RD;
            end
          end
        end
      end
      ST_LEFT_RD: begin
        cmd_o.rd_en = 1'b1;
        state_d     = ST_LEFT_EV;
      end
      ST_LEFT_EV: begin
        cmd_o.left_upd = 1'b1;
        if (sts_i.rd_end) begin
          nstart_d = addr_q + AW'(1);
          addr_d   = '0;
          j_d      = '0;
          first_d  = 1'b1;
          state_d  = ST_WALK_RD;
        end else begin
          addr_d  = addr_q + AW'(1);
          state_d = ST_LEFT_RD;
        end
      end
      ST_WALK_RD: begin
        cmd_o.rd_en = 1'b1;
        state_d     = ST_WALK_EV;
      end
      ST_WALK_EV: begin
        if (first_q) begin
          cmd_o.walk_first = 1'b1;
          first_d          = 1'b0;
        end else begin
          cmd_o.walk_next = 1'b1;
          cmd_o.edge_fire = j_q != ci_q;
        end
        if (sts_i.rd_end) begin
          state_d = ST_WALK_CL;
        end else begin
          addr_d  = addr_q + AW'(1);
          state_d = ST_WALK_RD;
        end
      end
      ST_WALK_CL: begin
        // closing edge from last vertex back to first
        cmd_o.edge_fire  = j_q != ci_q;
        cmd_o.edge_close = 1'b1;
        if (j_q == ccnt_last) begin
          state_d = ST_DRAIN;
        end else begin
          j_d     = j_q + CCW'(1);
          first_d = 1'b1;
          addr_d  = addr_q + AW'(1);
          state_d = ST_WALK_RD;
        end
      end
      ST_DRAIN: begin
        if (sts_i.pipe_empty) begin
          out_load = 1'b1;
          state_d  = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_ready_i) begin
          if (olast_q) begin
            vcnt_d  = '0;
            start_d = '0;
            ccnt_d  = '0;
            ovf_d   = 1'b0;
            state_d = ST_LOAD;
          end else begin
            ci_d            = ci_q + CCW'(1);
            addr_d          = nstart_q;
            cmd_o.left_init = 1'b1;
            cmd_o.cnt_clr   = 1'b1;
            state_d         = ST_LEFT_RD;
          end
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_LOAD;
      vcnt_q   <= '0;
      start_q  <= '0;
      ccnt_q   <= '0;
      ovf_q    <= 1'b0;
      ci_q     <= '0;
      j_q      <= '0;
      first_q  <= 1'b0;
      addr_q   <= '0;
      nstart_q <= '0;
    end else begin
      state_q  <= state_d;
      vcnt_q   <= vcnt_d;
      start_q  <= start_d;
      ccnt_q   <= ccnt_d;
      ovf_q    <= ovf_d;
      ci_q     <= ci_d;
      j_q      <= j_d;
      first_q  <= first_d;
      addr_q   <= addr_d;
      nstart_q <= nstart_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      oidx_q  <= IDX_W'(ci_q);
      ocnt_q  <= CNT_OUT_W'(count_i);
      olast_q <= ci_q == ccnt_last;
    end
  end

  assign in_ready_o  = state_q == ST_LOAD;
  assign out_valid_o = state_q == ST_EMIT;
  assign out_idx_o   = oidx_q;
  assign out_cnt_o   = ocnt_q;
  assign out_ovf_o   = ovf_q;
  assign out_last_o  = olast_q;
  assign wr_addr_o   = vcnt_q[AW-1:0];
  assign end_addr_o  = stored ? vcnt_q[AW-1:0] : vcnt_prev[AW-1:0];
  assign rd_addr_o   = addr_q;

endmodule

FILE: verif/contour_parity_crossing_count_core_tb.sv
// testbench for the contour parity core: directed table and random glyphs against a predictor
`timescale 1ns / 1ps
module contour_parity_crossing_count_core_tb;
  import cpcc_pkg::*;

  localparam int unsigned MAX_VERTICES = 256;
  localparam int unsigned MAX_CONTOURS = 16;
  localparam int unsigned COORD_BITS   = 18;
  localparam int unsigned IN_DW        = ((2*COORD_BITS+7)/8)*8;
  localparam int unsigned PAD_W        = IN_DW - 2*COORD_BITS;
  localparam int unsigned RANDOM_BEATS = 400;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned N_DIRECTED   = 24;
  localparam longint      LEFT_X       = LEFT_START_X;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef enum {GLYPH_PLAIN, GLYPH_NOISE, GLYPH_VERTEX_FULL, GLYPH_CONTOUR_FULL} glyph_kind_e;

  typedef struct {
    coord_t           x;
    coord_t           y;
    bit               contour_end;
    bit               glyph_end;
    logic [PAD_W-1:0] pad;
    bit               typed;
    int unsigned      typed_count;
    bit               typed_ovf;
  } vertex_beat_t;

  typedef struct {
    logic [IDX_W-1:0]     index;
    logic [CNT_OUT_W-1:0] count;
    bit                   overflow;
    bit                   last;
  } parity_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready_o;
  logic [IN_DW-1:0]     s_axis_tdata = '0;
  logic                 s_axis_tuser = 1'b0;
  logic                 s_axis_tlast = 1'b0;
  logic                 m_axis_tvalid_o;
  logic                 m_axis_tready = 1'b0;
  logic [OUT_DW-1:0]    m_axis_tdata_o;
  logic                 m_axis_tuser_o;
  logic                 m_axis_tlast_o;

  always #5 clk_i = ~clk_i;

  contour_parity_crossing_count_core #(
    .MAX_VERTICES(MAX_VERTICES),
    .MAX_CONTOURS(MAX_CONTOURS),
    .COORD_BITS  (COORD_BITS)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata),
    .s_axis_tuser_i (s_axis_tuser),
    .s_axis_tlast_i (s_axis_tlast),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

  // outline store mirrored by the predictor
  coord_t      outline_x [MAX_VERTICES];
  coord_t      outline_y [MAX_VERTICES];
  int unsigned contour_last [MAX_CONTOURS];
  int unsigned stored_vertices = 0;
  int unsigned stored_contours = 0;
  bit          dropped = 1'b0;

  parity_t     pending_parities [$];
  parity_t     got_parity;
  int unsigned mismatches = 0;
  int unsigned parities_checked = 0;
  int unsigned glyphs_done = 0;
  int unsigned beats_sent = 0;
  int unsigned cycle_cnt = 0;
  int unsigned hold_cnt = 0;
  bit          tx_burst = 1'b0;
  bit          rx_burst = 1'b0;

  vertex_beat_t directed_rows [N_DIRECTED] = '{
    '{0, 0, 0, 1, 0, 1, 0, 0},
    '{-131072, -131072, 0, 0, 0, 0, 0, 0},
    '{131071, 131071, 0, 0, 4'hf, 0, 0, 0},
    '{-131072, 131071, 0, 1, 4'ha, 1, 0, 0},
    '{-100, -100, 0, 0, 0, 0, 0, 0},
    '{100, -100, 0, 0, 0, 0, 0, 0},
    '{100, 100, 0, 0, 0, 0, 0, 0},
    '{-100, 100, 1, 0, 0, 0, 0, 0},
    '{-50, -50, 0, 0, 0, 0, 0, 0},
    '{50, -50, 0, 0, 0, 0, 0, 0},
    '{50, 50, 0, 0, 0, 0, 0, 0},
    '{-50, 50, 0, 1, 0, 0, 0, 0},
    '{65536, 5, 0, 0, 0, 0, 0, 0},
    '{131071, 10, 0, 0, 0, 0, 0, 0},
    '{70000, -10, 1, 0, 0, 0, 0, 0},
    '{0, -5, 0, 0, 0, 0, 0, 0},
    '{10, 5, 0, 0, 0, 0, 0, 0},
    '{-5, 5, 0, 1, 0, 0, 0, 0},
    '{-10, -10, 0, 0, 0, 0, 0, 0},
    '{30, 10, 0, 0, 0, 0, 0, 0},
    '{-10, 10, 1, 0, 0, 0, 0, 0},
    '{5, 0, 0, 0, 0, 0, 0, 0},
    '{6, 1, 0, 0, 0, 0, 0, 0},
    '{5, 1, 1, 1, 0, 0, 0, 0}
  };

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    else if (r < 85) return $urandom_range(1, 3);
    else if (r < 97) return $urandom_range(4, 12);
    else return $urandom_range(20, 60);
  endfunction

  function automatic coord_t pick_coord(int unsigned mode);
    if (mode == 1) return coord_t'($urandom);
    if (mode == 2 && $urandom_range(0, 1) == 0) begin
      case ($urandom_range(0, 5))
        0: return coord_t'(-131072);
        1: return coord_t'(131071);
        2: return coord_t'(-1);
        3: return coord_t'(65535);
        4: return coord_t'(65536);
        default: return coord_t'(0);
      endcase
    end
    return coord_t'(int'($urandom_range(0, 128)) - 64);
  endfunction

  function automatic vertex_beat_t make_beat(coord_t x, coord_t y, bit ce, bit ge,
                                             logic [PAD_W-1:0] pad);
    vertex_beat_t b;
    b.x = x;
    b.y = y;
    b.contour_end = ce;
    b.glyph_end = ge;
    b.pad = pad;
    b.typed = 1'b0;
    b.typed_count = 0;
    b.typed_ovf = 1'b0;
    return b;
  endfunction

  function automatic int unsigned contour_first(int unsigned c);
    return (c == 0) ? 0 : contour_last[c-1] + 1;
  endfunction

  // edges of the other contours crossed by a ray leftwards from the leftmost vertex
  function automatic int unsigned crossings_left_of(int unsigned ci);
    longint      lx, ly, x1, y1, x2, y2;
    int unsigned cnt, n, j, k, k2;
    lx = LEFT_X;
    ly = 0;
    cnt = 0;
    for (n = contour_first(ci); n <= contour_last[ci]; n++) begin
      if (outline_x[n] < lx) begin
        lx = outline_x[n];
        ly = outline_y[n];
      end
    end
    for (j = 0; j < stored_contours; j++) begin
      if (j == ci) continue;
      for (k = contour_first(j); k <= contour_last[j]; k++) begin
        k2 = (k == contour_last[j]) ? contour_first(j) : k + 1;
        x1 = outline_x[k];
        y1 = outline_y[k];
        x2 = outline_x[k2];
        y2 = outline_y[k2];
        if ((y1 < ly && y2 < ly) || (y1 >= ly && y2 >= ly) || (x1 > lx && x2 > lx)) continue;
        if (x1 < lx && x2 < lx) cnt++;
        else if ((x2 - lx) * (y1 - ly) > (y2 - ly) * (x1 - lx)) cnt++;
      end
    end
    return cnt;
  endfunction

  task automatic predict_beat(input vertex_beat_t b);
    int unsigned s, i, cnt;
    parity_t     p;
    if (stored_vertices < MAX_VERTICES) begin
      outline_x[stored_vertices] = b.x;
      outline_y[stored_vertices] = b.y;
      stored_vertices++;
    end else begin
      dropped = 1'b1;
    end
    if (b.contour_end || b.glyph_end) begin
      s = contour_first(stored_contours);
      if (stored_vertices != s) begin
        if (stored_contours >= MAX_CONTOURS) begin
          stored_vertices = s;
          dropped = 1'b1;
        end else begin
          contour_last[stored_contours] = stored_vertices - 1;
          stored_contours++;
        end
      end
    end
    if (b.glyph_end) begin
      for (i = 0; i < stored_contours; i++) begin
        cnt = b.typed ? b.typed_count : crossings_left_of(i);
        p.index = i[IDX_W-1:0];
        p.count = cnt[CNT_OUT_W-1:0];
        p.overflow = b.typed ? b.typed_ovf : dropped;
        p.last = (i + 1 == stored_contours);
        pending_parities.push_back(p);
      end
      stored_vertices = 0;
      stored_contours = 0;
      dropped = 1'b0;
      glyphs_done++;
    end
  endtask

  task automatic send_beat(input vertex_beat_t b);
    int unsigned gap;
    gap = tx_burst ? 0 : idle_len();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {b.pad, b.y, b.x};
    s_axis_tuser <= b.contour_end;
    s_axis_tlast <= b.glyph_end;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    predict_beat(b);
    beats_sent++;
  endtask

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // result checking and receiver back-pressure
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready) begin
      if (pending_parities.size() == 0) begin
        $error("result beat with nothing expected: tdata %h", m_axis_tdata_o);
        mismatches++;
      end else begin
        got_parity = pending_parities.pop_front();
        if (m_axis_tdata_o[IDX_W-1:0] !== got_parity.index) begin
          $error("contour_index: expected %0d, actual %0d", got_parity.index,
                 m_axis_tdata_o[IDX_W-1:0]);
          mismatches++;
        end
        if (m_axis_tdata_o[IDX_W +: CNT_OUT_W] !== got_parity.count) begin
          $error("crossing_count: expected %0d, actual %0d", got_parity.count,
                 m_axis_tdata_o[IDX_W +: CNT_OUT_W]);
          mismatches++;
        end
        if (m_axis_tuser_o !== got_parity.overflow) begin
          $error("overflow: expected %0d, actual %0d", got_parity.overflow, m_axis_tuser_o);
          mismatches++;
        end
        if (m_axis_tlast_o !== got_parity.last) begin
          $error("last_contour: expected %0d, actual %0d", got_parity.last, m_axis_tlast_o);
          mismatches++;
        end
        parities_checked++;
      end
    end
    if ($urandom_range(0, 299) == 0) rx_burst <= ~rx_burst;
    if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
      m_axis_tready <= 1'b0;
    end else if (!rx_burst && $urandom_range(0, 3) == 0) begin
      hold_cnt <= idle_len();
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  initial begin
    vertex_beat_t glyph_beats [$];
    glyph_kind_e  kind;
    int unsigned  g, r, mode, nc, nv, c, v, random_beats;
    bit           ge, ce;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    tx_burst = 1'b0;
    foreach (directed_rows[i]) send_beat(directed_rows[i]);

    g = 0;
    random_beats = 0;
    while (random_beats < RANDOM_BEATS) begin
      tx_burst = ($urandom_range(0, 3) == 0);
      glyph_beats.delete();
      r = $urandom_range(0, 99);
      if (g == 2) kind = GLYPH_VERTEX_FULL;
      else if (g == 5 || g == 11) kind = GLYPH_CONTOUR_FULL;
      else if (r < 12) kind = GLYPH_NOISE;
      else kind = GLYPH_PLAIN;
      case (kind)
        GLYPH_VERTEX_FULL: begin
          // fifteen contours fill all but one slot, later beats are dropped
          for (c = 0; c < 15; c++)
            for (v = 0; v < 17; v++)
              glyph_beats.push_back(make_beat(pick_coord(0), pick_coord(0), v == 16, 0, '0));
          for (v = 0; v < 5; v++)
            glyph_beats.push_back(make_beat(pick_coord(0), pick_coord(0), v == 4, 0, '0));
          glyph_beats.push_back(make_beat(pick_coord(0), pick_coord(0), 1, 0, '0));
          glyph_beats.push_back(make_beat(pick_coord(1), pick_coord(1), 1, 0, '0));
          glyph_beats.push_back(make_beat(pick_coord(0), pick_coord(0), 0, 1, '0));
        end
        GLYPH_CONTOUR_FULL: begin
          nc = $urandom_range(17, 19);
          for (c = 0; c < nc; c++) begin
            nv = $urandom_range(1, 3);
            for (v = 0; v < nv; v++) begin
              ge = (c == nc - 1) && (v == nv - 1);
              glyph_beats.push_back(make_beat(pick_coord(0), pick_coord(0),
                                              v == nv - 1 && !ge, ge, '0));
            end
          end
        end
        GLYPH_NOISE: begin
          nv = $urandom_range(1, 16);
          for (v = 0; v < nv; v++)
            glyph_beats.push_back(make_beat(pick_coord(1), pick_coord(1),
                                            $urandom_range(0, 2) == 0, v == nv - 1,
                                            PAD_W'($urandom)));
        end
        default: begin
          mode = (r < 60) ? 0 : (r < 85) ? 1 : 2;
          nc = $urandom_range(1, 5);
          for (c = 0; c < nc; c++) begin
            nv = $urandom_range(1, 8);
            for (v = 0; v < nv; v++) begin
              ge = (c == nc - 1) && (v == nv - 1);
              ce = (v == nv - 1) ? (ge ? bit'($urandom_range(0, 1)) : 1'b1) : 1'b0;
              glyph_beats.push_back(make_beat(pick_coord(mode), pick_coord(mode), ce, ge, '0));
            end
          end
        end
      endcase
      foreach (glyph_beats[i]) send_beat(glyph_beats[i]);
      random_beats += glyph_beats.size();
      g++;
    end
    s_axis_tvalid <= 1'b0;

    while (pending_parities.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);

    $display("run covered %0d glyphs from %0d vertex beats, %0d parity beats checked",
             glyphs_done, beats_sent, parities_checked);
    $display("including full vertex memory, full contour table and noise glyphs; %0d mismatches",
             mismatches);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
